// ===== design/complex_arith_unit_macros.svh =====
// Assertion macros shared by the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) else $error(msg);
`else
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/cau_pkg.sv =====
package cau_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int CMD_W      = 3;
    localparam int STAT_W     = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MAG = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ANG = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVF  = 2'd1;
    localparam logic [STAT_W-1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]             cmd;
        logic signed [DATA_WIDTH-1:0] a_re;
        logic signed [DATA_WIDTH-1:0] a_im;
        logic signed [DATA_WIDTH-1:0] b_re;
        logic signed [DATA_WIDTH-1:0] b_im;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_re;
        logic signed [DATA_WIDTH-1:0] res_im;
        logic [STAT_W-1:0]            status;
    } t_out_word;

    // Product and sum widths.
    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int SM_W   = PROD_W + 2;

    // Divider: quotients above DIV_LIM integer units always clamp.
    localparam longint DIV_LIM = (longint'(1) << (DATA_WIDTH - 1)) >>> FRAC_BITS;
    localparam int DIV_QB = $clog2((DIV_LIM + 1) << (FRAC_BITS + 1));
    localparam int DIV_SH = DIV_QB - FRAC_BITS - 1;
    localparam int OV_W   = PROD_W + DATA_WIDTH - FRAC_BITS;
    localparam logic [OV_W-1:0] DIV_LIM1 = OV_W'(DIV_LIM + 1);

    // Vectoring CORDIC, angle kept in units of 2^-32 rad.
    localparam int ANG_FRAC     = 32;
    localparam int CORDIC_STEPS = 32;
    localparam int CORDIC_PRE   = 28;
    localparam int CX_W         = DATA_WIDTH + CORDIC_PRE + 4;
    localparam int CZ_W         = 36;
    localparam int ANG_SH       = ANG_FRAC - FRAC_BITS;
    localparam logic signed [CZ_W-1:0] PI_ANG = 36'sd13493037705;

    typedef struct packed {
        logic                  ovf;
        logic [DATA_WIDTH-1:0] val;
    } t_sat;

    // Clamp a sign-magnitude value to the signed output range.
    function automatic t_sat sat_sm(input logic neg, input logic [SM_W-1:0] mag);
        logic [SM_W-1:0]       lim;
        logic [DATA_WIDTH-1:0] m;
        t_sat                  r;
        lim   = (SM_W'(1) << (DATA_WIDTH - 1)) - (neg ? SM_W'(0) : SM_W'(1));
        r.ovf = mag > lim;
        m     = r.ovf ? lim[DATA_WIDTH-1:0] : mag[DATA_WIDTH-1:0];
        r.val = neg ? (~m + 1'b1) : m;
        return r;
    endfunction

    // atan(2^-i) in units of 2^-32 rad.
    function automatic logic signed [CZ_W-1:0] atan_lut(input int i);
        logic signed [CZ_W-1:0] t;
        unique case (i)
            0:  t = 36'sd3373259426;
            1:  t = 36'sd1991351318;
            2:  t = 36'sd1052175346;
            3:  t = 36'sd534100635;
            4:  t = 36'sd268086748;
            5:  t = 36'sd134174063;
            6:  t = 36'sd67103403;
            7:  t = 36'sd33553749;
            8:  t = 36'sd16777131;
            9:  t = 36'sd8388597;
            10: t = 36'sd4194303;
            default: t = CZ_W'(64'd1 << (ANG_FRAC - i));
        endcase
        return t;
    endfunction

endpackage

// ===== design/complex_arith_unit.sv =====
// Complex arithmetic unit, signed fixed point (cau_pkg::DATA_WIDTH bits,
// cau_pkg::FRAC_BITS of them fractional).
// Input channel: i_valid / o_stall with word i_word (command and operands a, b).
// Output channel: o_valid / i_stall with word o_word (real and imaginary result
// and status). A word moves at a clock edge where valid is high and stall low.
// Commands: add, subtract, multiply, divide, magnitude of a, angle of a.
// Every command runs through the same 34 pipeline registers (the input
// register and 33 stages), so results appear on o_word in the order in which
// their input words were accepted.
// One word is accepted every cycle unless the output stalls; the depth is set
// by the 32 CORDIC iterations of the angle path, with the divider (17 quotient
// steps) and square root (16 root steps) running beside it in the same stages.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline; no results are
// pending afterwards and the block accepts a word in the next cycle.
`include "complex_arith_unit_macros.svh"

module complex_arith_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cau_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  logic                i_stall,
    output cau_pkg::t_out_word  o_word
);
    import cau_pkg::*;

    localparam int W         = DATA_WIDTH;
    localparam int S_SUM     = 2;
    localparam int S_MUL     = 3;
    localparam int S_SQ0     = 3;
    localparam int S_MAG     = S_SQ0 + W - 1;
    localparam int S_DIVP    = 3;
    localparam int S_DIV0    = S_DIVP + 1;
    localparam int S_DIVR    = S_DIV0 + DIV_QB - 1;
    localparam int S_CZ0     = 2;
    localparam int S_ANG     = S_CZ0 + CORDIC_STEPS - 1;
    localparam int PIPE_LAST = S_ANG;
    localparam logic signed [W-1:0] PI_Q =
        W'((PI_ANG + (CZ_W'(1) <<< (ANG_SH - 1))) >>> ANG_SH);

    logic en;
    logic [PIPE_LAST:0] r_vld;
    t_in_word           r_in;
    logic [CMD_W-1:0]   r_cmd [1:PIPE_LAST];
    t_out_word          r_res [1:PIPE_LAST];

    // Stage 1 products.
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [PROD_W-1:0] r_p_arar, r_p_aiai, r_p_brbr, r_p_bibi;
    // Stage 2 sums.
    logic signed [PROD_W:0]   r_mre, r_mim, r_nre, r_nim;
    logic [PROD_W-1:0]        r_den;

    // Divider stages.
    logic [PROD_W-1:0] r_drem_re [S_DIVP:S_DIVR-1];
    logic [PROD_W-1:0] r_drem_im [S_DIVP:S_DIVR-1];
    logic [DIV_QB-1:0] r_dq_re   [S_DIVP:S_DIVR-1];
    logic [DIV_QB-1:0] r_dq_im   [S_DIVP:S_DIVR-1];
    logic [DIV_SH-1:0] r_dlo_re  [S_DIVP:S_DIVR-1];
    logic [DIV_SH-1:0] r_dlo_im  [S_DIVP:S_DIVR-1];
    logic [PROD_W-1:0] r_dden    [S_DIVP:S_DIVR-1];
    logic              r_dneg_re [S_DIVP:S_DIVR-1];
    logic              r_dneg_im [S_DIVP:S_DIVR-1];
    logic              r_dov_re  [S_DIVP:S_DIVR-1];
    logic              r_dov_im  [S_DIVP:S_DIVR-1];
    logic              r_ddz     [S_DIVP:S_DIVR-1];

    // Square root stages.
    logic [PROD_W-1:0] r_srem  [S_SUM:S_MAG-1];
    logic [W-1:0]      r_sroot [S_SUM:S_MAG-1];

    // CORDIC stages.
    logic signed [CX_W-1:0] r_cx   [S_CZ0-1:S_ANG-1];
    logic signed [CX_W-1:0] r_cy   [S_CZ0-1:S_ANG-1];
    logic signed [CZ_W-1:0] r_cz   [S_CZ0-1:S_ANG-1];
    logic                   r_cfix [S_CZ0-1:S_ANG-1];
    logic                   r_cneg [S_CZ0-1:S_ANG-1];

    t_out_word n_add_res, n_mul_res, n_div_res, n_mag_res, n_ang_res;

    // The pipeline moves as one; it holds only while the last stage is blocked.
    assign en      = !(r_vld[PIPE_LAST] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[PIPE_LAST];
    assign o_word  = r_res[PIPE_LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in <= i_word;
        end
    end

    // ---------------- add and subtract, stage 1 ----------------
    logic signed [W:0] n_as_sum;
    logic [W:0]        n_as_mag;
    t_sat              n_as_re, n_as_im;
    logic signed [W:0] n_as_sum_im;
    logic [W:0]        n_as_mag_im;

    always_comb begin
        if (r_in.cmd == CMD_SUB) begin
            n_as_sum    = (W+1)'(r_in.a_re) - (W+1)'(r_in.b_re);
            n_as_sum_im = (W+1)'(r_in.a_im) - (W+1)'(r_in.b_im);
        end else begin
            n_as_sum    = (W+1)'(r_in.a_re) + (W+1)'(r_in.b_re);
            n_as_sum_im = (W+1)'(r_in.a_im) + (W+1)'(r_in.b_im);
        end
        n_as_mag    = n_as_sum[W] ? -n_as_sum : n_as_sum;
        n_as_mag_im = n_as_sum_im[W] ? -n_as_sum_im : n_as_sum_im;
        n_as_re     = sat_sm(n_as_sum[W], SM_W'(n_as_mag));
        n_as_im     = sat_sm(n_as_sum_im[W], SM_W'(n_as_mag_im));
        n_add_res   = '0;
        if (r_in.cmd == CMD_ADD || r_in.cmd == CMD_SUB) begin
            n_add_res.res_re = n_as_re.val;
            n_add_res.res_im = n_as_im.val;
            n_add_res.status = (n_as_re.ovf || n_as_im.ovf) ? ST_OVF : ST_OK;
        end
    end

    // ---------------- products and sums, stages 1 and 2 ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_rr   <= r_in.a_re * r_in.b_re;
            r_p_ii   <= r_in.a_im * r_in.b_im;
            r_p_ri   <= r_in.a_re * r_in.b_im;
            r_p_ir   <= r_in.a_im * r_in.b_re;
            r_p_arar <= r_in.a_re * r_in.a_re;
            r_p_aiai <= r_in.a_im * r_in.a_im;
            r_p_brbr <= r_in.b_re * r_in.b_re;
            r_p_bibi <= r_in.b_im * r_in.b_im;

            r_mre <= (PROD_W+1)'(r_p_rr) - (PROD_W+1)'(r_p_ii);
            r_mim <= (PROD_W+1)'(r_p_ri) + (PROD_W+1)'(r_p_ir);
            r_nre <= (PROD_W+1)'(r_p_rr) + (PROD_W+1)'(r_p_ii);
            r_nim <= (PROD_W+1)'(r_p_ir) - (PROD_W+1)'(r_p_ri);
            r_den <= PROD_W'(r_p_brbr) + PROD_W'(r_p_bibi);
            r_srem[S_SUM]  <= PROD_W'(r_p_arar) + PROD_W'(r_p_aiai);
            r_sroot[S_SUM] <= '0;
        end
    end

    // ---------------- multiply, rounding at stage 3 ----------------
    logic [PROD_W-1:0] n_mmag_re, n_mmag_im;
    logic [PROD_W:0]   n_mrnd_re, n_mrnd_im;
    t_sat              n_msat_re, n_msat_im;

    always_comb begin
        n_mmag_re = r_mre[PROD_W] ? PROD_W'(-r_mre) : PROD_W'(r_mre);
        n_mmag_im = r_mim[PROD_W] ? PROD_W'(-r_mim) : PROD_W'(r_mim);
        n_mrnd_re = ({1'b0, n_mmag_re} + (PROD_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_mrnd_im = ({1'b0, n_mmag_im} + (PROD_W+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        n_msat_re = sat_sm(r_mre[PROD_W], SM_W'(n_mrnd_re));
        n_msat_im = sat_sm(r_mim[PROD_W], SM_W'(n_mrnd_im));
        n_mul_res.res_re = n_msat_re.val;
        n_mul_res.res_im = n_msat_im.val;
        n_mul_res.status = (n_msat_re.ovf || n_msat_im.ovf) ? ST_OVF : ST_OK;
    end

    // ---------------- divide ----------------
    // The quotient is found by restoring long division, one bit per stage.
    // A numerator at or above (DIV_LIM + 1) times the denominator always clamps,
    // so only DIV_QB quotient bits (one of them a rounding guard) are needed.
    logic [PROD_W-1:0] n_dmag_re, n_dmag_im;

    assign n_dmag_re = r_nre[PROD_W] ? PROD_W'(-r_nre) : PROD_W'(r_nre);
    assign n_dmag_im = r_nim[PROD_W] ? PROD_W'(-r_nim) : PROD_W'(r_nim);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_drem_re[S_DIVP] <= n_dmag_re >> DIV_SH;
            r_drem_im[S_DIVP] <= n_dmag_im >> DIV_SH;
            r_dlo_re[S_DIVP]  <= n_dmag_re[DIV_SH-1:0];
            r_dlo_im[S_DIVP]  <= n_dmag_im[DIV_SH-1:0];
            r_dq_re[S_DIVP]   <= '0;
            r_dq_im[S_DIVP]   <= '0;
            r_dden[S_DIVP]    <= r_den;
            r_dneg_re[S_DIVP] <= r_nre[PROD_W];
            r_dneg_im[S_DIVP] <= r_nim[PROD_W];
            r_dov_re[S_DIVP]  <= OV_W'(n_dmag_re) >= DIV_LIM1 * OV_W'(r_den);
            r_dov_im[S_DIVP]  <= OV_W'(n_dmag_im) >= DIV_LIM1 * OV_W'(r_den);
            r_ddz[S_DIVP]     <= (r_den == '0);
        end
    end

    for (genvar j = 0; j < DIV_QB; j++) begin : g_div
        localparam int S = S_DIV0 + j;
        logic            nb_re, nb_im;
        logic [PROD_W:0] t_re, t_im;
        logic            ge_re, ge_im;

        if (j < DIV_SH) begin : g_bit
            assign nb_re = r_dlo_re[S-1][DIV_SH-1-j];
            assign nb_im = r_dlo_im[S-1][DIV_SH-1-j];
        end else begin : g_zero
            assign nb_re = 1'b0;
            assign nb_im = 1'b0;
        end

        assign t_re  = {r_drem_re[S-1], nb_re};
        assign t_im  = {r_drem_im[S-1], nb_im};
        assign ge_re = t_re >= {1'b0, r_dden[S-1]};
        assign ge_im = t_im >= {1'b0, r_dden[S-1]};

        if (S < S_DIVR) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_drem_re[S] <= ge_re ? PROD_W'(t_re - {1'b0, r_dden[S-1]})
                                          : PROD_W'(t_re);
                    r_drem_im[S] <= ge_im ? PROD_W'(t_im - {1'b0, r_dden[S-1]})
                                          : PROD_W'(t_im);
                    r_dq_re[S]   <= {r_dq_re[S-1][DIV_QB-2:0], ge_re};
                    r_dq_im[S]   <= {r_dq_im[S-1][DIV_QB-2:0], ge_im};
                    r_dlo_re[S]  <= r_dlo_re[S-1];
                    r_dlo_im[S]  <= r_dlo_im[S-1];
                    r_dden[S]    <= r_dden[S-1];
                    r_dneg_re[S] <= r_dneg_re[S-1];
                    r_dneg_im[S] <= r_dneg_im[S-1];
                    r_dov_re[S]  <= r_dov_re[S-1];
                    r_dov_im[S]  <= r_dov_im[S-1];
                    r_ddz[S]     <= r_ddz[S-1];
                end
            end
        end else begin : g_last
            logic [DIV_QB-1:0] q_re, q_im;
            logic [DIV_QB:0]   qr_re, qr_im;
            t_sat              ds_re, ds_im;

            assign q_re  = {r_dq_re[S-1][DIV_QB-2:0], ge_re};
            assign q_im  = {r_dq_im[S-1][DIV_QB-2:0], ge_im};
            assign qr_re = ({1'b0, q_re} + 1'b1) >> 1;
            assign qr_im = ({1'b0, q_im} + 1'b1) >> 1;
            assign ds_re = sat_sm(r_dneg_re[S-1],
                                  r_dov_re[S-1] ? (SM_W'(1) << W) : SM_W'(qr_re));
            assign ds_im = sat_sm(r_dneg_im[S-1],
                                  r_dov_im[S-1] ? (SM_W'(1) << W) : SM_W'(qr_im));

            always_comb begin
                if (r_ddz[S-1]) begin
                    n_div_res        = '0;
                    n_div_res.status = ST_DIVZ;
                end else begin
                    n_div_res.res_re = ds_re.val;
                    n_div_res.res_im = ds_im.val;
                    n_div_res.status = (ds_re.ovf || ds_im.ovf) ? ST_OVF : ST_OK;
                end
            end
        end
    end

    // ---------------- magnitude: one root bit per stage ----------------
    for (genvar j = 0; j < W; j++) begin : g_sqrt
        localparam int S = S_SQ0 + j;
        localparam int K = W - 1 - j;
        logic [PROD_W:0] trial;
        logic            take;
        logic [PROD_W-1:0] rem_n;
        logic [W-1:0]      root_n;

        assign trial  = ((PROD_W+1)'(r_sroot[S-1]) << (K + 1))
                      + ((PROD_W+1)'(1) << (2 * K));
        assign take   = {1'b0, r_srem[S-1]} >= trial;
        assign rem_n  = take ? PROD_W'({1'b0, r_srem[S-1]} - trial) : r_srem[S-1];
        assign root_n = take ? (r_sroot[S-1] | (W'(1) << K)) : r_sroot[S-1];

        if (S < S_MAG) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_srem[S]  <= rem_n;
                    r_sroot[S] <= root_n;
                end
            end
        end else begin : g_last
            logic [W:0] root_r;
            t_sat       ms;

            // Round to nearest: bump the floor root when the remainder exceeds it.
            assign root_r = {1'b0, root_n} + ((rem_n > PROD_W'(root_n)) ? 1'b1 : 1'b0);
            assign ms     = sat_sm(1'b0, SM_W'(root_r));

            always_comb begin
                n_mag_res        = '0;
                n_mag_res.res_re = ms.val;
                n_mag_res.status = ms.ovf ? ST_OVF : ST_OK;
            end
        end
    end

    // ---------------- angle: vectoring CORDIC ----------------
    logic                   n_cfix, n_cneg, n_cflip;
    logic signed [CX_W-1:0] n_cx0, n_cy0;

    always_comb begin
        n_cfix  = (r_in.a_im == '0);
        n_cneg  = r_in.a_re[W-1];
        n_cflip = !n_cfix && n_cneg;
        n_cx0   = CX_W'(r_in.a_re);
        n_cy0   = CX_W'(r_in.a_im);
        if (n_cflip) begin
            n_cx0 = -n_cx0;
            n_cy0 = -n_cy0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx[S_CZ0-1]   <= n_cx0 <<< CORDIC_PRE;
            r_cy[S_CZ0-1]   <= n_cy0 <<< CORDIC_PRE;
            // A vector in the left half plane, off the real axis, is first turned by pi.
            r_cz[S_CZ0-1]   <= !n_cflip ? '0 : (r_in.a_im > 0 ? PI_ANG : -PI_ANG);
            r_cfix[S_CZ0-1] <= n_cfix;
            r_cneg[S_CZ0-1] <= n_cneg;
        end
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
        localparam int S = S_CZ0 + j;
        localparam logic signed [CZ_W-1:0] T = atan_lut(j);
        logic                   up;
        logic signed [CX_W-1:0] dx, dy, x_n, y_n;
        logic signed [CZ_W-1:0] z_n;

        assign up  = r_cy[S-1] > 0;
        assign dx  = r_cy[S-1] >>> j;
        assign dy  = r_cx[S-1] >>> j;
        assign x_n = up ? r_cx[S-1] + dx : r_cx[S-1] - dx;
        assign y_n = up ? r_cy[S-1] - dy : r_cy[S-1] + dy;
        assign z_n = up ? r_cz[S-1] + T  : r_cz[S-1] - T;

        if (S < S_ANG) begin : g_reg
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_cx[S]   <= x_n;
                    r_cy[S]   <= y_n;
                    r_cz[S]   <= z_n;
                    r_cfix[S] <= r_cfix[S-1];
                    r_cneg[S] <= r_cneg[S-1];
                end
            end
        end else begin : g_last
            logic signed [CZ_W-1:0] zf;
            logic [CZ_W-1:0]        zmag;
            logic [CZ_W-1:0]        zrnd;
            t_sat                   as;

            // A vector on the real axis has an exact angle of zero or pi.
            assign zf   = r_cfix[S-1] ? (r_cneg[S-1] ? PI_ANG : '0) : z_n;
            assign zmag = zf[CZ_W-1] ? CZ_W'(-zf) : CZ_W'(zf);
            assign zrnd = (zmag + (CZ_W'(1) << (ANG_SH - 1))) >> ANG_SH;
            assign as   = sat_sm(zf[CZ_W-1], SM_W'(zrnd));

            always_comb begin
                n_ang_res        = '0;
                n_ang_res.res_re = as.val;
                n_ang_res.status = as.ovf ? ST_OVF : ST_OK;
            end
        end
    end

    // ---------------- result word travelling with each item ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd[1] <= r_in.cmd;
            r_res[1] <= n_add_res;
        end
    end

    for (genvar s = 2; s <= PIPE_LAST; s++) begin : g_res
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cmd[s] <= r_cmd[s-1];
                if (s == S_MUL && r_cmd[s-1] == CMD_MUL) begin
                    r_res[s] <= n_mul_res;
                end else if (s == S_MAG && r_cmd[s-1] == CMD_MAG) begin
                    r_res[s] <= n_mag_res;
                end else if (s == S_DIVR && r_cmd[s-1] == CMD_DIV) begin
                    r_res[s] <= n_div_res;
                end else if (s == S_ANG && r_cmd[s-1] == CMD_ANG) begin
                    r_res[s] <= n_ang_res;
                end else begin
                    r_res[s] <= r_res[s-1];
                end
            end
        end
    end

    `CAU_ASSERT(a_polar_im_zero, i_clk, i_rst_n, (o_valid && (r_cmd[PIPE_LAST] == CMD_MAG || r_cmd[PIPE_LAST] == CMD_ANG)) |-> (o_word.res_im == '0), "magnitude or angle word has a nonzero imaginary part")
    `CAU_ASSERT(a_divz_only_div, i_clk, i_rst_n, (o_valid && o_word.status == ST_DIVZ) |-> (r_cmd[PIPE_LAST] == CMD_DIV && o_word.res_re == '0 && o_word.res_im == '0), "divide-by-zero status on a wrong word")
    `CAU_ASSERT(a_angle_range, i_clk, i_rst_n, (o_valid && r_cmd[PIPE_LAST] == CMD_ANG) |-> (o_word.res_re <= PI_Q && o_word.res_re >= -PI_Q), "angle outside plus or minus pi")
    `CAU_ASSERT_NEXT(a_hold_valids, i_clk, i_rst_n, (!en), ($stable(r_vld)), "pipeline valid bits moved during a stall")

endmodule

// ===== tb/complex_arith_unit_tb.sv =====
`timescale 1ns / 100ps

module complex_arith_unit_tb;
    import cau_pkg::*;

    localparam longint ATAN_STEP0 = 64'sd3373259426;
    localparam longint PI_UNITS   = 64'sd13493037705;
    localparam int     LATENCY    = 33;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;

    t_in_word  pending_words[$];
    t_out_word expected_results[$];
    int        mismatches;
    int        results_seen;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    int        op_count[8];
    bit        stim_done;
    bit        in_taken;

    complex_arith_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint atan_step(input int i);
        longint t;
        case (i)
            0: t = ATAN_STEP0;
            1: t = 64'sd1991351318;
            2: t = 64'sd1052175346;
            3: t = 64'sd534100635;
            4: t = 64'sd268086748;
            5: t = 64'sd134174063;
            6: t = 64'sd67103403;
            7: t = 64'sd33553749;
            8: t = 64'sd16777131;
            9: t = 64'sd8388597;
            10: t = 64'sd4194303;
            default: t = longint'(64'd1 << (32 - i));
        endcase
        return t;
    endfunction

    // Signed value clamped to the output range; sets ovf when it clamps.
    function automatic logic [DATA_WIDTH-1:0] clamp_field(input longint v, inout bit ovf);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
        lo = -(64'sd1 <<< (DATA_WIDTH - 1));
        if (v > hi) begin
            ovf = 1;
            v = hi;
        end else if (v < lo) begin
            ovf = 1;
            v = lo;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // Round-half-away-from-zero of v / 2^k.
    function automatic longint round_away(input longint v, input int k);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 <<< (k - 1))) >>> k;
        return v < 0 ? -m : m;
    endfunction

    // Rounded n * 2^FRAC_BITS / d with the sign of n; huge quotients map to a
    // value that always clamps.
    function automatic longint fixed_quotient(input longint n, input longint d);
        longint m;
        longint q;
        longint r;
        m = n < 0 ? -n : n;
        q = m / d;
        r = m % d;
        if (q > ((64'sd1 <<< (DATA_WIDTH - 1)) >>> FRAC_BITS)) begin
            q = 64'sd1 <<< DATA_WIDTH;
        end else begin
            for (int i = 0; i <= FRAC_BITS; i++) begin
                r = r <<< 1;
                q = q <<< 1;
                if (r >= d) begin
                    r = r - d;
                    q = q | 1;
                end
            end
            q = (q + 1) >>> 1;
        end
        return n < 0 ? -q : q;
    endfunction

    function automatic longint rounded_sqrt(input longint s);
        longint rem;
        longint root;
        longint bitv;
        rem = s;
        root = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > rem) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem = rem - root - bitv;
                root = (root >>> 1) + bitv;
            end else begin
                root = root >>> 1;
            end
            bitv = bitv >>> 2;
        end
        if (rem > root) root++;
        return root;
    endfunction

    // Vectoring CORDIC; >>> on signed longint is a floor shift.
    function automatic longint cordic_angle(input longint x, input longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (y == 0) return x < 0 ? PI_UNITS : 0;
        if (x < 0) begin
            z = y > 0 ? PI_UNITS : -PI_UNITS;
            x = -x;
            y = -y;
        end
        x = x <<< 28;
        y = y <<< 28;
        for (int i = 0; i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_step(i);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic t_out_word complex_result(input t_in_word w);
        t_out_word r;
        bit        ovf;
        longint    ar, ai, br, bi, d;
        ar = longint'(w.a_re);
        ai = longint'(w.a_im);
        br = longint'(w.b_re);
        bi = longint'(w.b_im);
        ovf = 0;
        r = '0;
        r.status = ST_OK;
        case (w.cmd)
            CMD_ADD: begin
                r.res_re = clamp_field(ar + br, ovf);
                r.res_im = clamp_field(ai + bi, ovf);
            end
            CMD_SUB: begin
                r.res_re = clamp_field(ar - br, ovf);
                r.res_im = clamp_field(ai - bi, ovf);
            end
            CMD_MUL: begin
                r.res_re = clamp_field(round_away(ar * br - ai * bi, FRAC_BITS), ovf);
                r.res_im = clamp_field(round_away(ar * bi + ai * br, FRAC_BITS), ovf);
            end
            CMD_DIV: begin
                d = br * br + bi * bi;
                if (d != 0) begin
                    r.res_re = clamp_field(fixed_quotient(ar * br + ai * bi, d), ovf);
                    r.res_im = clamp_field(fixed_quotient(ai * br - ar * bi, d), ovf);
                end
            end
            CMD_MAG: r.res_re = clamp_field(rounded_sqrt(ar * ar + ai * ai), ovf);
            CMD_ANG: r.res_re = clamp_field(round_away(cordic_angle(ar, ai), 20), ovf);
            default: ;
        endcase
        if (w.cmd == CMD_DIV && br == 0 && bi == 0) r.status = ST_DIVZ;
        else if (ovf) r.status = ST_OVF;
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] random_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return DATA_WIDTH'($urandom_range(0, 8)) - 16'd4;
            4, 5: return DATA_WIDTH'($urandom_range(0, 16383)) - 16'd8192;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [DATA_WIDTH-1:0] ar,
                              input logic [DATA_WIDTH-1:0] ai, input logic [DATA_WIDTH-1:0] br,
                              input logic [DATA_WIDTH-1:0] bi);
        t_in_word w;
        w.cmd = cmd;
        w.a_re = ar;
        w.a_im = ai;
        w.b_re = br;
        w.b_im = bi;
        pending_words.push_back(w);
    endtask

    initial begin
        t_in_word w;
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_word = '0;
        mismatches = 0;
        results_seen = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        stim_done = 0;
        in_taken = 0;
        foreach (op_count[k]) op_count[k] = 0;

        queue_word(CMD_ADD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        queue_word(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        queue_word(CMD_ADD, 16'h1000, 16'hf000, 16'h0001, 16'hffff);
        queue_word(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        queue_word(CMD_MUL, 16'h1000, 16'h2000, 16'hf000, 16'h0800);
        queue_word(CMD_MUL, 16'h0001, 16'h0000, 16'h0800, 16'h0000);
        queue_word(CMD_DIV, 16'h1000, 16'h1000, 16'h0000, 16'h0000);
        queue_word(CMD_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
        queue_word(CMD_DIV, 16'h1000, 16'h0000, 16'h0000, 16'h1000);
        queue_word(CMD_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
        queue_word(CMD_MAG, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        queue_word(CMD_MAG, 16'h3000, 16'h4000, 16'h0000, 16'h0000);
        queue_word(CMD_ANG, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_word(CMD_ANG, 16'hf000, 16'h0000, 16'h0000, 16'h0000);
        queue_word(CMD_ANG, 16'h8000, 16'h0001, 16'h0000, 16'h0000);
        queue_word(CMD_ANG, 16'h8000, 16'hffff, 16'h0000, 16'h0000);
        queue_word(CMD_ANG, 16'h0000, 16'h7fff, 16'h0000, 16'h0000);
        queue_word(CMD_ANG, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
        queue_word(CMD_ANG, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000);
        queue_word(3'd6, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
        queue_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

        for (int n = 0; n < 1400; n++) begin
            w.cmd = CMD_W'($urandom_range(0, 7));
            if (w.cmd > CMD_ANG && $urandom_range(0, 3) != 0)
                w.cmd = CMD_W'($urandom_range(0, 5));
            w.a_re = random_operand();
            w.a_im = random_operand();
            w.b_re = random_operand();
            w.b_im = random_operand();
            // Small denominators stress the divider's clamp and zero cases.
            if (w.cmd == CMD_DIV && $urandom_range(0, 4) == 0) begin
                w.b_re = DATA_WIDTH'($urandom_range(0, 2)) - 16'd1;
                w.b_im = DATA_WIDTH'($urandom_range(0, 2)) - 16'd1;
            end
            pending_words.push_back(w);
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        wait (pending_words.size() == 0 && !i_valid);
        wait (expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        stim_done = 1;
        $display("Ran %0d words: add %0d sub %0d mul %0d div %0d mag %0d ang %0d undef %0d",
                 results_seen, op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4], op_count[5], op_count[6] + op_count[7]);
        $display("with random input gaps and output stalls; %0d mismatches", mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout at %0t", $realtime);
        $display("FAILED: results differ");
        $finish;
    end

    // Driver: bursts of words separated by random gaps.
    // The monitor records at the rising edge whether the offered word was taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (i_valid) pending_words.pop_front();
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (burst_left > 0 && pending_words.size() > 0) begin
                    burst_left--;
                    i_valid <= 1;
                    i_word <= pending_words[0];
                end else begin
                    if (gap_left > 0) gap_left--;
                    else burst_left = 0;
                    i_valid <= 0;
                end
            end
            stall_phase++;
            // Stall pattern: stall-free stretches alternate with random stalling.
            if ((stall_phase / 200) % 3 == 0) i_stall <= 0;
            else if ((stall_phase / 200) % 3 == 1) i_stall <= ($urandom_range(0, 3) == 0);
            else i_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge i_clk) begin
        t_out_word exp_word;
        if (i_rst_n) begin
            in_taken = i_valid && !o_stall;
            if (in_taken) begin
                expected_results.push_back(complex_result(i_word));
                op_count[i_word.cmd]++;
            end
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word %h", $realtime, o_word);
                end else begin
                    exp_word = expected_results.pop_front();
                    if (o_word.res_re !== exp_word.res_re || o_word.res_im !== exp_word.res_im ||
                        o_word.status !== exp_word.status) begin
                        mismatches++;
                        $display("%0t: expected re %h im %h st %0d, got re %h im %h st %0d",
                                 $realtime, exp_word.res_re, exp_word.res_im, exp_word.status,
                                 o_word.res_re, o_word.res_im, o_word.status);
                    end
                end
            end
        end
    end

endmodule

// ===== files.f =====
+incdir+design
design/cau_pkg.sv
design/complex_arith_unit.sv
tb/complex_arith_unit_tb.sv
